>>> hw/rtl/adaptive_tile_sample_scheduler_defines.svh
// Assertion helpers shared by the scheduler top level.
`ifndef ADAPTIVE_TILE_SAMPLE_SCHEDULER_DEFINES_SVH
`define ADAPTIVE_TILE_SAMPLE_SCHEDULER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define ATS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Check cons in the cycle after ante.
`define ATS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

>>> hw/rtl/ats_pkg.sv
package ats_pkg;

	localparam int TILE_SIZE     = 16;
	localparam int TILE_BITS     = $clog2(TILE_SIZE);
	localparam int MAX_COUNT     = 40;
	localparam int CHANNELS      = 3;
	localparam int MAX_TILES_DEF = 4096;

	localparam int MODE_W     = 2;
	localparam int TILE_W     = 12;
	localparam int REQ_W      = 16;
	localparam int PIX_W      = 10;
	localparam int FACTOR_W   = 6;
	localparam int GEOM_W     = 7;
	localparam int GEOM_MAX   = 64;
	localparam int COORD_W    = PIX_W - TILE_BITS;
	localparam int SC_W       = $clog2(MAX_COUNT * CHANNELS + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTORED_EN  = 2'd2;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic finish;
	} ats_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ats_sts_t;

endpackage

>>> hw/rtl/ats_in_if.sv
interface ats_in_if import ats_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic [TILE_W-1:0]       block_index;
	logic signed [REQ_W-1:0] requested_samples;
	logic [PIX_W-1:0]        query_x;
	logic [PIX_W-1:0]        query_y;

	modport source (output valid, mode, block_index, requested_samples, query_x, query_y,
		input ready);
	modport sink (input valid, mode, block_index, requested_samples, query_x, query_y,
		output ready);
endinterface

>>> hw/rtl/ats_out_if.sv
interface ats_out_if import ats_pkg::*;;
	logic                valid;
	logic                ready;
	logic [PIX_W-1:0]    pixel_x;
	logic [PIX_W-1:0]    pixel_y;
	logic [TILE_W-1:0]   tile_number;
	logic [FACTOR_W-1:0] factor;
	logic                standard_path;

	modport source (output valid, pixel_x, pixel_y, tile_number, factor, standard_path,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, tile_number, factor, standard_path,
		output ready);
endinterface

>>> hw/rtl/ats_cfg_if.sv
interface ats_cfg_if import ats_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ats_ctrl.sv
module ats_ctrl import ats_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ats_cmd_t cmd,
	input  ats_sts_t sts
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd.clear_step = (state_q == ST_CLEAR);
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.finish     = (state_q == ST_BUSY) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_BUSY;
			end
			ST_BUSY: begin
				if (cmd.finish) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/ats_dp.sv
module ats_dp import ats_pkg::*; #(
	parameter int MAX_TILES = MAX_TILES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ats_cmd_t                cmd,
	output ats_sts_t                sts,
	input  logic [MODE_W-1:0]       mode,
	input  logic [TILE_W-1:0]       block_index,
	input  logic signed [REQ_W-1:0] requested_samples,
	input  logic [PIX_W-1:0]        query_x,
	input  logic [PIX_W-1:0]        query_y,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic [PIX_W-1:0]        pixel_x,
	output logic [PIX_W-1:0]        pixel_y,
	output logic [TILE_W-1:0]       tile_number,
	output logic [FACTOR_W-1:0]     factor,
	output logic                    standard_path
);

	localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int XW = 17;
	localparam int QW = TILE_W + 1;
	localparam logic [XW-1:0] TILES_LIM = XW'(MAX_TILES);

	function automatic logic [GEOM_W-1:0] geom(input logic [GEOM_W-1:0] v);
		logic [GEOM_W-1:0] r;
		r = v;
		if (v == '0) r = GEOM_W'(1);
		else if (v > GEOM_W'(GEOM_MAX)) r = GEOM_W'(GEOM_MAX);
		return r;
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [TILE_W-1:0] v);
		logic [XW-1:0] w;
		w = XW'(v);
		return w[AW-1:0];
	endfunction

	logic [GEOM_W-1:0]   across_q;
	logic [GEOM_W-1:0]   down_q;
	logic                fen_q;
	logic [GEOM_W-1:0]   across_g;
	logic [GEOM_W-1:0]   down_g;
	logic [2*GEOM_W-1:0] total;

	logic [FACTOR_W-1:0] mem [MAX_TILES];
	logic [FACTOR_W-1:0] rd_q;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       clr_q;

	logic [FACTOR_W-1:0] clamped;
	logic                blk_ok;
	logic [QW-1:0]       qidx;
	logic                qidx_ok;

	logic [MODE_W-1:0]   mode_q;
	logic [TILE_W-1:0]   blk_q;
	logic [FACTOR_W-1:0] set_f_q;
	logic [PIX_W-1:0]    qx_q;
	logic [PIX_W-1:0]    qy_q;
	logic [TILE_W-1:0]   qidx_q;
	logic                qidx_ok_q;
	logic                ti_ok_q;

	logic [SC_W-1:0]      sc_q;
	logic [TILE_BITS-1:0] x_q;
	logic [TILE_BITS-1:0] y_q;
	logic [TILE_W-1:0]    ti_q;
	logic [COORD_W-1:0]   col_q;
	logic [COORD_W-1:0]   row_q;

	logic [FACTOR_W-1:0]  f_walk;
	logic [SC_W:0]        lim;
	logic [SC_W:0]        sc_inc;
	logic [TILE_BITS:0]   x_inc;
	logic [TILE_BITS:0]   y_inc;
	logic [TILE_W:0]      ti_inc;
	logic [COORD_W:0]     col_inc;
	logic                 ti_wrap;
	logic                 walk_step;

	logic [PIX_W-1:0]    res_px;
	logic [PIX_W-1:0]    res_py;
	logic [TILE_W-1:0]   res_tile;
	logic [FACTOR_W-1:0] res_f;
	logic                res_std;

	logic [PIX_W-1:0]    px_q;
	logic [PIX_W-1:0]    py_q;
	logic [TILE_W-1:0]   tile_q;
	logic [FACTOR_W-1:0] f_q;
	logic                std_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q <= GEOM_W'(1);
			down_q   <= GEOM_W'(1);
			fen_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TILES_ACROSS: across_q <= cfg_data;
				REG_TILES_DOWN:   down_q   <= cfg_data;
				REG_FACTORED_EN:  fen_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign across_g = geom(across_q);
	assign down_g   = geom(down_q);
	assign total    = (2*GEOM_W)'(across_g) * (2*GEOM_W)'(down_g);

	always_comb begin
		if (requested_samples < 1) clamped = FACTOR_W'(1);
		else if (requested_samples > MAX_COUNT) clamped = FACTOR_W'(MAX_COUNT);
		else clamped = requested_samples[FACTOR_W-1:0];
	end

	assign blk_ok  = XW'(block_index) < TILES_LIM;
	assign qidx    = QW'(query_y >> TILE_BITS) * QW'(across_g) + QW'(query_x >> TILE_BITS);
	assign qidx_ok = XW'(qidx) < TILES_LIM;
	assign rd_addr = (mode == MODE_NEXT) ? to_addr(ti_q) : to_addr(qidx[TILE_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.clear_step) mem[clr_q] <= FACTOR_W'(1);
		else if (cmd.accept && (mode == MODE_SET) && blk_ok)
			mem[to_addr(block_index)] <= clamped;
		if (cmd.accept) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + 1'b1;
	end

	assign sts.clear_last = (clr_q == AW'(MAX_TILES - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q    <= mode;
			blk_q     <= block_index;
			set_f_q   <= blk_ok ? clamped : FACTOR_W'(1);
			qx_q      <= query_x;
			qy_q      <= query_y;
			qidx_q    <= qidx[TILE_W-1:0];
			qidx_ok_q <= qidx_ok;
			ti_ok_q   <= XW'(ti_q) < TILES_LIM;
		end
	end

	assign f_walk    = ti_ok_q ? rd_q : FACTOR_W'(1);
	assign lim       = (SC_W+1)'(f_walk * CHANNELS);
	assign sc_inc    = (SC_W+1)'(sc_q) + 1'b1;
	assign x_inc     = (TILE_BITS+1)'(x_q) + 1'b1;
	assign y_inc     = (TILE_BITS+1)'(y_q) + 1'b1;
	assign ti_inc    = (TILE_W+1)'(ti_q) + 1'b1;
	assign col_inc   = (COORD_W+1)'(col_q) + 1'b1;
	assign ti_wrap   = (XW'(ti_inc) >= XW'(total)) || (XW'(ti_inc) >= TILES_LIM);
	assign walk_step = cmd.finish && (mode_q == MODE_NEXT) && fen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q  <= '0;
			x_q   <= '0;
			y_q   <= '0;
			ti_q  <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (walk_step) begin
			if (sc_inc < lim) begin
				sc_q <= sc_inc[SC_W-1:0];
			end else begin
				sc_q <= '0;
				if (x_inc < (TILE_BITS+1)'(TILE_SIZE)) begin
					x_q <= x_inc[TILE_BITS-1:0];
				end else begin
					x_q <= '0;
					if (y_inc < (TILE_BITS+1)'(TILE_SIZE)) begin
						y_q <= y_inc[TILE_BITS-1:0];
					end else begin
						y_q <= '0;
						if (ti_wrap) begin
							ti_q  <= '0;
							col_q <= '0;
							row_q <= '0;
						end else begin
							ti_q <= ti_inc[TILE_W-1:0];
							if (col_inc >= across_g) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_inc[COORD_W-1:0];
							end
						end
					end
				end
			end
		end
	end

	always_comb begin
		res_px   = '0;
		res_py   = '0;
		res_tile = '0;
		res_f    = FACTOR_W'(1);
		res_std  = 1'b0;
		case (mode_q)
			MODE_NEXT: begin
				if (fen_q) begin
					res_px   = PIX_W'({col_q, x_q});
					res_py   = PIX_W'({row_q, y_q});
					res_tile = ti_q;
					res_f    = f_walk;
				end else begin
					res_std = 1'b1;
				end
			end
			MODE_SET: begin
				res_tile = blk_q;
				res_f    = set_f_q;
			end
			MODE_QUERY: begin
				res_px   = qx_q;
				res_py   = qy_q;
				res_tile = qidx_q;
				if (fen_q && qidx_ok_q) res_f = rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			px_q   <= res_px;
			py_q   <= res_py;
			tile_q <= res_tile;
			f_q    <= res_f;
			std_q  <= res_std;
		end
	end

	assign pixel_x       = px_q;
	assign pixel_y       = py_q;
	assign tile_number   = tile_q;
	assign factor        = f_q;
	assign standard_path = std_q;

endmodule

>>> hw/rtl/adaptive_tile_sample_scheduler.sv
// channel   side    handshake     payload
// request   sink    valid/ready   mode, block_index, requested_samples, query_x, query_y
// result    source  valid/ready   pixel_x, pixel_y, tile_number, factor, standard_path
// cfg       sink    valid/ready   index, data; ready is always high
//
// Each item passes IDLE, with capture and count table read, then BUSY, with result and walk update;
// the next item is taken only after BUSY is left. The count table has a single read port.
// After reset a clearing pass writes 1 to all MAX_TILES entries (4096 by default);
// request.ready stays low during it, cfg writes are taken.
// A full result register holds the BUSY state; the next item is taken once it moves on.
`include "adaptive_tile_sample_scheduler_defines.svh"

module adaptive_tile_sample_scheduler import ats_pkg::*; #(
	parameter int MAX_TILES = MAX_TILES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ats_in_if.sink       request,
	ats_out_if.source    result,
	ats_cfg_if.sink      cfg
);

	ats_cmd_t cmd;
	ats_sts_t sts;

	ats_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ats_dp #(
		.MAX_TILES (MAX_TILES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.mode              (request.mode),
		.block_index       (request.block_index),
		.requested_samples (request.requested_samples),
		.query_x           (request.query_x),
		.query_y           (request.query_y),
		.cfg_valid         (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.pixel_x           (result.pixel_x),
		.pixel_y           (result.pixel_y),
		.tile_number       (result.tile_number),
		.factor            (result.factor),
		.standard_path     (result.standard_path)
	);

	assign cfg.ready = 1'b1;

	`ATS_ASSERT_NOW(a_no_overlap, cmd.accept, !cmd.finish)
	`ATS_ASSERT_NEXT(a_accept_busy, cmd.accept, !request.ready)
	`ATS_ASSERT_NEXT(a_finish_shows, cmd.finish, result.valid)
	`ATS_ASSERT_NOW(a_factor_range, result.valid, (result.factor != '0) && (result.factor <= FACTOR_W'(MAX_COUNT)))

endmodule
